@@ hdl/vrlp_pkg.sv @@
// ----------------------------------------------------------------------------
// vrlp_pkg
// Types, keyword table and character codes for the request line parser.
// ----------------------------------------------------------------------------
package vrlp_pkg;

	typedef enum logic [2:0] {
		KIND_UNDEF = 3'd0,
		KIND_BAD   = 3'd1,
		KIND_GET   = 3'd2,
		KIND_START = 3'd3,
		KIND_PAUSE = 3'd4,
		KIND_END   = 3'd5,
		KIND_ALIVE = 3'd6
	} req_kind_t;

	localparam int KW_COUNT  = 8;
	localparam int KW_MAXLEN = 13;

	localparam int KW_IDX_GET    = 0;
	localparam int KW_IDX_START  = 1;
	localparam int KW_IDX_PAUSE  = 2;
	localparam int KW_IDX_END    = 3;
	localparam int KW_IDX_ALIVE  = 4;
	localparam int KW_IDX_MINUS1 = 7;

	localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
		"GET", "START", "PAUSE", "END", "ALIVE", "LISTEN_PORT", "FRAGMENT_SIZE", "-1"
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd5, 4'd5, 4'd3, 4'd5, 4'd11, 4'd13, 4'd2
	};

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [30:0] NUM_MAX    = 31'h7fffffff;
	localparam logic [31:0] IMG_ABSENT = 32'hfffffffe;
	localparam logic [31:0] NUM_UNSET  = 32'hffffffff;

	// true when keyword k still agrees with character c at position idx
	function automatic logic kw_char_match(input int k, input logic [3:0] idx,
			input logic [7:0] c);
		int pos;
		logic ok;
		ok = 1'b0;
		if (idx < KW_LEN[k]) begin
			pos = int'(KW_LEN[k]) - 1 - int'(idx);
			ok = (KW_TEXT[k][pos*8 +: 8] == c);
		end
		return ok;
	endfunction

endpackage

@@ hdl/video_request_line_parser.sv @@
// ----------------------------------------------------------------------------
// video_request_line_parser
// Byte-wise parser of a streaming server request line into command fields.
// ----------------------------------------------------------------------------
// Request bytes enter on the input channel (byte_in, in_valid, in_stall), one
// transaction per byte. Words are split by space, CR and LF; word 0 is the
// command, word 1 the image number, word 3 the listen port and word 5 the
// fragment size. A request ends on the second LF of a separator run that did
// not close a word; one result transaction then leaves on the output channel
// (req_type, image_id, client_port, frag_size, out_valid, out_stall) and
// the parser starts over with the next byte.
// Throughput is one byte per cycle while in_stall is low: the parse state is
// updated by one short step (keyword compare, one multiply-by-ten and add)
// per byte. The final LF of a request first waits in the input register, and
// out_valid rises when the result register is loaded.
// Reset clears the parse state and both valid flags. While the receiver
// stalls a waiting result, bytes keep being parsed; only a byte that would
// end another request holds the input register, and in_stall rises.
// ----------------------------------------------------------------------------
module video_request_line_parser
	import vrlp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         byte_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         req_type,
	output logic signed [31:0] image_id,
	output logic signed [31:0] client_port,
	output logic signed [31:0] frag_size
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic        inside_q;
	logic [3:0]  wlen_q;
	logic [7:0]  cand_q;
	logic [30:0] num_q;
	logic        digits_q;
	logic [2:0]  fpos_q;
	logic [1:0]  nl_q;
	req_kind_t   kind_q;
	logic [31:0] image_q;
	logic [31:0] port_q;
	logic [31:0] frag_q;

	logic        out_valid_q;
	req_kind_t   req_type_q;
	logic [31:0] image_id_q;
	logic [31:0] client_port_q;
	logic [31:0] frag_size_q;

	logic        sep;
	logic        is_digit;
	logic        emit;
	logic        adv;
	logic [3:0]  wl_base;
	logic [7:0]  cand_base;
	logic [30:0] num_base;
	logic [7:0]  cand_next;
	logic [3:0]  wlen_next;
	logic [34:0] num_prod;
	logic [30:0] num_next;
	logic [7:0]  kw_hit;
	logic        num_ok;
	logic [31:0] num_val;
	req_kind_t   kw_kind;
	req_kind_t   emit_kind;

	assign sep      = (byte_s1 == CHAR_SPACE) || (byte_s1 == CHAR_LF) || (byte_s1 == CHAR_CR);
	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign emit     = valid_s1 && sep && !inside_q && (byte_s1 == CHAR_LF) && (nl_q == 2'd1);
	assign adv      = !(out_valid_q && out_stall) || !emit;
	assign in_stall = valid_s1 && !adv;

	// word start values
	assign wl_base   = inside_q ? wlen_q : 4'd0;
	assign cand_base = inside_q ? cand_q : 8'hff;
	assign num_base  = inside_q ? num_q  : 31'd0;

	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			cand_next[k] = cand_base[k] && kw_char_match(k, wl_base, byte_s1);
			kw_hit[k]    = cand_q[k] && (wlen_q == KW_LEN[k]);
		end
	end

	assign wlen_next = (wl_base == 4'd15) ? wl_base : wl_base + 4'd1;
	assign num_prod  = {1'b0, num_base, 3'b000} + {3'b000, num_base, 1'b0}
		+ {27'd0, byte_s1 - CHAR_ZERO};
	assign num_next  = (num_prod > {4'd0, NUM_MAX}) ? NUM_MAX : num_prod[30:0];

	assign num_ok  = kw_hit[KW_IDX_MINUS1] || digits_q;
	assign num_val = kw_hit[KW_IDX_MINUS1] ? NUM_UNSET : {1'b0, num_q};

	always_comb begin
		if (kw_hit[KW_IDX_GET])
			kw_kind = KIND_GET;
		else if (kw_hit[KW_IDX_START])
			kw_kind = KIND_START;
		else if (kw_hit[KW_IDX_PAUSE])
			kw_kind = KIND_PAUSE;
		else if (kw_hit[KW_IDX_END])
			kw_kind = KIND_END;
		else if (kw_hit[KW_IDX_ALIVE])
			kw_kind = KIND_ALIVE;
		else
			kw_kind = KIND_BAD;
	end

	assign emit_kind = (((kind_q == KIND_GET) || (kind_q == KIND_ALIVE))
		&& (image_q == IMG_ABSENT)) ? KIND_BAD : kind_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_in;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			wlen_q   <= 4'd0;
			cand_q   <= 8'hff;
			num_q    <= 31'd0;
			digits_q <= 1'b1;
			fpos_q   <= 3'd0;
			nl_q     <= 2'd0;
			kind_q   <= KIND_UNDEF;
			image_q  <= IMG_ABSENT;
			port_q   <= NUM_UNSET;
			frag_q   <= NUM_UNSET;
		end else if (valid_s1 && adv) begin
			if (inside_q && sep) begin
				inside_q <= 1'b0;
				unique case (fpos_q)
					3'd0: kind_q <= kw_kind;
					3'd1: image_q <= num_ok ? num_val : 32'd0;
					3'd3: begin
						if (num_ok)
							port_q <= num_val;
						else
							kind_q <= KIND_BAD;
					end
					3'd5: begin
						if (num_ok)
							frag_q <= num_val;
						else
							kind_q <= KIND_BAD;
					end
					default: ;
				endcase
				if (fpos_q != 3'd7)
					fpos_q <= fpos_q + 3'd1;
			end else if (!sep) begin
				if (!inside_q)
					nl_q <= 2'd0;
				inside_q <= 1'b1;
				wlen_q   <= wlen_next;
				cand_q   <= cand_next;
				num_q    <= is_digit ? num_next : num_base;
				digits_q <= (inside_q ? digits_q : 1'b1) && is_digit;
			end else if (emit) begin
				inside_q <= 1'b0;
				wlen_q   <= 4'd0;
				cand_q   <= 8'hff;
				num_q    <= 31'd0;
				digits_q <= 1'b1;
				fpos_q   <= 3'd0;
				nl_q     <= 2'd0;
				kind_q   <= KIND_UNDEF;
				image_q  <= IMG_ABSENT;
				port_q   <= NUM_UNSET;
				frag_q   <= NUM_UNSET;
			end else if (byte_s1 == CHAR_LF) begin
				nl_q <= nl_q + 2'd1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && adv) begin
			req_type_q    <= emit_kind;
			image_id_q    <= image_q;
			client_port_q <= port_q;
			frag_size_q   <= frag_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign req_type    = req_type_q;
	assign image_id    = image_id_q;
	assign client_port = client_port_q;
	assign frag_size   = frag_size_q;

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && emit) |-> in_stall)
		else $error("result register overwritten while stalled");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && emit && out_valid_q))
		else $error("input stalled without a blocked result");

	a_undef_defaults: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (req_type_q == KIND_UNDEF)) |->
		((image_id_q == IMG_ABSENT) && (client_port_q == NUM_UNSET)
		&& (frag_size_q == NUM_UNSET)))
		else $error("empty request carries field values");

	a_get_has_image: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ((req_type_q == KIND_GET) || (req_type_q == KIND_ALIVE)))
		|-> (image_id_q != IMG_ABSENT))
		else $error("get or alive emitted without image number");

endmodule

@@ tb/video_request_line_parser_test.sv @@
// ----------------------------------------------------------------------------
// video_request_line_parser_test
// Self-checking bench for the byte-wise request line parser.
// ----------------------------------------------------------------------------
// Request text goes in one byte per transaction. A model in the bench parses
// the same bytes and queues the fields of each finished request, and every
// result transaction is checked field by field against the oldest entry.
// Directed requests cover the commands, number limits and odd framing, with
// idle bursts on both channels. A long output hold fills the block. A short
// run of random requests with noise closes the test, with no idle bursts.
// ----------------------------------------------------------------------------
module video_request_line_parser_test;
	import vrlp_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLD_CYCLES    = 300;
	localparam int REPORT_LIMIT   = 10;
	localparam int FIELD_COMMAND  = 0;
	localparam int FIELD_IMAGE    = 1;
	localparam int FIELD_PORT     = 3;
	localparam int FIELD_FRAGMENT = 5;
	localparam int FIELD_LAST     = 7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] image;
		logic [31:0] port;
		logic [31:0] frag;
	} request_fields_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         byte_in;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         req_type;
	logic signed [31:0] image_id;
	logic signed [31:0] client_port;
	logic signed [31:0] frag_size;

	video_request_line_parser uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.byte_in     (byte_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.req_type    (req_type),
		.image_id    (image_id),
		.client_port (client_port),
		.frag_size   (frag_size)
	);

	string keyword_text [KW_COUNT] = '{
		"GET", "START", "PAUSE", "END", "ALIVE", "LISTEN_PORT", "FRAGMENT_SIZE", "-1"
	};
	string command_words [12] = '{
		"GET", "START", "PAUSE", "END", "ALIVE", "GETS", "get", "ALIV",
		"PAUSED", "-1", "LISTEN_PORT", "EN"
	};

	// parser model state
	logic       in_word;
	logic [3:0] word_len;
	logic [7:0] candidates;
	logic [30:0] acc_value;
	logic       all_digits;
	logic [2:0] word_index;
	logic [1:0] lf_count;
	req_kind_t  cmd_kind;
	logic [31:0] image_num;
	logic [31:0] port_num;
	logic [31:0] frag_num;

	request_fields_t pending_requests [$];
	request_fields_t expected_fields;
	logic [7:0]      request_bytes [$];

	int  cycle_count;
	int  failures;
	int  requests_checked;
	int  bytes_sent;
	int  kind_seen [8];
	bit  idling_on;
	bit  hold_request;
	int  stall_len;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_requests.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void clear_request();
		in_word    = 1'b0;
		word_len   = '0;
		candidates = '1;
		acc_value  = '0;
		all_digits = 1'b1;
		word_index = '0;
		lf_count   = '0;
		cmd_kind   = KIND_UNDEF;
		image_num  = IMG_ABSENT;
		port_num   = NUM_UNSET;
		frag_num   = NUM_UNSET;
	endfunction

	function automatic bit keyword_hit(input int k);
		return candidates[k] && (int'(word_len) == keyword_text[k].len());
	endfunction

	// advances the model by one byte, returns 1 when a request is complete
	function automatic bit parse_byte(input logic [7:0] c, output request_fields_t fields);
		bit          sep;
		bit          num_ok;
		logic [31:0] num;
		int unsigned d;
		int unsigned acc;
		req_kind_t   k;
		sep = (c == CHAR_SPACE) || (c == CHAR_LF) || (c == CHAR_CR);
		fields = '0;
		parse_byte = 1'b0;
		if (in_word && sep) begin
			in_word = 1'b0;
			num_ok = keyword_hit(KW_IDX_MINUS1) || all_digits;
			num = keyword_hit(KW_IDX_MINUS1) ? NUM_UNSET : {1'b0, acc_value};
			case (int'(word_index))
				FIELD_COMMAND: begin
					if (keyword_hit(KW_IDX_GET))
						cmd_kind = KIND_GET;
					else if (keyword_hit(KW_IDX_START))
						cmd_kind = KIND_START;
					else if (keyword_hit(KW_IDX_PAUSE))
						cmd_kind = KIND_PAUSE;
					else if (keyword_hit(KW_IDX_END))
						cmd_kind = KIND_END;
					else if (keyword_hit(KW_IDX_ALIVE))
						cmd_kind = KIND_ALIVE;
					else
						cmd_kind = KIND_BAD;
				end
				FIELD_IMAGE: image_num = num_ok ? num : '0;
				FIELD_PORT: begin
					if (num_ok)
						port_num = num;
					else
						cmd_kind = KIND_BAD;
				end
				FIELD_FRAGMENT: begin
					if (num_ok)
						frag_num = num;
					else
						cmd_kind = KIND_BAD;
				end
				default: ;
			endcase
			if (int'(word_index) != FIELD_LAST)
				word_index++;
		end else if (!sep) begin
			if (!in_word) begin
				lf_count   = '0;
				in_word    = 1'b1;
				word_len   = '0;
				candidates = '1;
				acc_value  = '0;
				all_digits = 1'b1;
			end
			for (int i = 0; i < KW_COUNT; i++) begin
				if (int'(word_len) >= keyword_text[i].len() || keyword_text[i][word_len] != c)
					candidates[i] = 1'b0;
			end
			if (word_len != 4'd15)
				word_len++;
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				d = c - CHAR_ZERO;
				acc = acc_value;
				if (acc > ({1'b0, NUM_MAX} - d) / 10)
					acc = {1'b0, NUM_MAX};
				else
					acc = acc * 10 + d;
				acc_value = acc[30:0];
			end else begin
				all_digits = 1'b0;
			end
		end else begin
			if (c == CHAR_LF)
				lf_count++;
			if (lf_count == 2'd2) begin
				k = cmd_kind;
				if ((k == KIND_GET || k == KIND_ALIVE) && image_num == IMG_ABSENT)
					k = KIND_BAD;
				fields.kind  = k;
				fields.image = image_num;
				fields.port  = port_num;
				fields.frag  = frag_num;
				clear_request();
				parse_byte = 1'b1;
			end
		end
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b);
		request_fields_t fields;
		if (idling_on && $urandom_range(0, 9) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid = 1'b1;
		byte_in = b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		if (parse_byte(b, fields))
			pending_requests.push_back(fields);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_queued_bytes();
		while (request_bytes.size() != 0)
			send_byte(request_bytes.pop_front());
	endtask

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			request_bytes.push_back(s[i]);
	endfunction

	function automatic void push_digits(input int n);
		for (int i = 0; i < n; i++)
			request_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void push_word();
		int n;
		int r;
		n = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 37);
			if (r < 26)
				request_bytes.push_back(8'h41 + 8'(r));
			else if (r < 36)
				request_bytes.push_back(CHAR_ZERO + 8'(r - 26));
			else
				request_bytes.push_back(r == 36 ? 8'h5f : 8'h2d);
		end
	endfunction

	// separator run that never holds two LFs, so it cannot end the request
	function automatic void push_gap();
		bit lf_used;
		int r;
		lf_used = 1'b0;
		for (int i = $urandom_range(1, 3); i > 0; i--) begin
			r = $urandom_range(0, 5);
			if (r == 0 && !lf_used) begin
				request_bytes.push_back(CHAR_LF);
				lf_used = 1'b1;
			end else begin
				request_bytes.push_back(r < 3 ? CHAR_SPACE : CHAR_CR);
			end
		end
	endfunction

	function automatic void push_end();
		case ($urandom_range(0, 3))
			0: push_text("\n\n\n");
			1: push_text("\r\n\r\n");
			2: push_text(" \n \n");
			default: push_text("\n\r\n\n");
		endcase
	endfunction

	function automatic void push_number();
		case ($urandom_range(0, 7))
			0, 1: push_digits($urandom_range(1, 4));
			2: push_digits($urandom_range(9, 14));
			3: push_text("-1");
			4: push_text($urandom_range(0, 1) ? "2147483647" : "2147483648");
			5: begin
				push_text("-");
				push_digits($urandom_range(0, 3));
			end
			6: push_text($urandom_range(0, 1) ? "0" : "007");
			default: push_word();
		endcase
	endfunction

	function automatic void build_random_request();
		int shape;
		shape = $urandom_range(0, 11);
		if (shape == 0) begin
			for (int i = $urandom_range(1, 24); i > 0; i--)
				request_bytes.push_back(8'($urandom_range(0, 255)));
			push_end();
		end else if (shape == 1) begin
			push_text("\n\n");
		end else begin
			if ($urandom_range(0, 4) == 0)
				push_word();
			else
				push_text(command_words[$urandom_range(0, 11)]);
			if (shape > 2 || $urandom_range(0, 1)) begin
				push_gap();
				push_number();
			end
			if (shape > 3) begin
				push_gap();
				if ($urandom_range(0, 3) == 0) push_word(); else push_text("LISTEN_PORT");
				push_gap();
				push_number();
				push_gap();
				if ($urandom_range(0, 3) == 0) push_word(); else push_text("FRAGMENT_SIZE");
				push_gap();
				push_number();
				if (shape == 11) begin
					for (int i = $urandom_range(1, 4); i > 0; i--) begin
						push_gap();
						push_word();
					end
				end
			end
			push_end();
		end
	endfunction

	task automatic test_commands();
		send_text("GET 5 LISTEN_PORT 8080 FRAGMENT_SIZE 1400\r\n\r\n");
		send_text("START -1 LISTEN_PORT 1 FRAGMENT_SIZE 2\n\n\n");
		send_text("PAUSE\n\n\n");
		send_text("END\n\n\n");
		send_text("ALIVE 3\n\n\n");
		send_text("HELLO 1\n\n\n");
		send_text("GET\n\n\n");
	endtask

	task automatic test_numbers();
		send_text("GET 2147483647 LISTEN_PORT 0 FRAGMENT_SIZE 2147483648\n\n\n");
		send_text("START 99999999999 LISTEN_PORT 4294967296 FRAGMENT_SIZE 007\n\n\n");
		send_text("GET abc\n\n\n");
		send_text("START 1 LISTEN_PORT x1 FRAGMENT_SIZE -1\n\n\n");
		send_text("PAUSE 1 LISTEN_PORT 9 FRAGMENT_SIZE -2\n\n\n");
	endtask

	task automatic test_special_cases();
		send_text("\n\n");
		send_text("END\n\n");
		send_text("\n");
		send_text("GETGETGETGETGETGETGET 1\n\n\n");
		send_text("START 1 a 2 b 3 c d e f g 4\n\n\n");
		send_byte(8'h00);
		send_byte(8'hff);
		send_text(" 12\n\n\n");
		send_text("END\n\nPAUSE 4\n\n\n");
	endtask

	task automatic test_output_hold();
		hold_request = 1'b1;
		for (int i = 0; i < 8; i++)
			send_text(i[0] ? "END\n\n\n" : "ALIVE 7\n\n\n");
	endtask

	task automatic test_random_traffic();
		int first_byte;
		first_byte = bytes_sent;
		idling_on = 1'b0;
		while (bytes_sent - first_byte < 24) begin
			build_random_request();
			send_queued_bytes();
		end
	endtask

	// output side: random stall bursts and one long hold
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 1'b0;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				stall_len = $urandom_range(1, 14);
				out_stall = 1'b1;
				repeat (stall_len) @(negedge clk);
				out_stall = 1'b0;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			requests_checked++;
			kind_seen[req_type]++;
			if (pending_requests.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected transaction: kind %0d image %0d port %0d fragment %0d",
						req_type, image_id, client_port, frag_size);
			end else begin
				expected_fields = pending_requests.pop_front();
				if (req_type !== expected_fields.kind || image_id !== expected_fields.image ||
						client_port !== expected_fields.port ||
						frag_size !== expected_fields.frag) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
							expected_fields.kind, $signed(expected_fields.image),
							$signed(expected_fields.port), $signed(expected_fields.frag),
							req_type, image_id, client_port, frag_size);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = '0;
		idling_on = 1'b1;
		hold_request = 1'b0;
		clear_request();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_commands();
		test_numbers();
		test_special_cases();
		test_output_hold();
		test_random_traffic();

		while (pending_requests.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d requests checked from %0d bytes: undefined %0d, bad %0d, get %0d, start %0d,",
			requests_checked, bytes_sent, kind_seen[KIND_UNDEF], kind_seen[KIND_BAD],
			kind_seen[KIND_GET], kind_seen[KIND_START]);
		$display("pause %0d, end %0d, alive %0d; idle bursts, a %0d-cycle output hold, %0d errors",
			kind_seen[KIND_PAUSE], kind_seen[KIND_END], kind_seen[KIND_ALIVE], HOLD_CYCLES,
			failures);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
